### design/xtvl_pkg.sv
// Shared types, codes and constants for the XML tag value locator.
`timescale 1ns / 1ps
package xtvl_pkg;

  localparam int unsigned DEF_MAX_TAG_CHARS    = 16;
  localparam int unsigned DEF_MAX_REGION_BYTES = 65536;

  localparam int unsigned TAG_BYTES  = 16;
  localparam int unsigned VAL_W      = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [7:0] CHAR_LT    = 8'h3C;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_GT    = 8'h3E;

  localparam logic [4:0]       RST_TAG_LENGTH    = 5'd1;
  localparam logic [VAL_W-1:0] RST_OCCURRENCE    = 16'd0;
  localparam logic [VAL_W-1:0] RST_MAX_VALUE_LEN = 16'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TAG_LENGTH     = 3'd0,
    REG_TAG_CHARS_LOW  = 3'd1,
    REG_TAG_CHARS_HIGH = 3'd2,
    REG_OCCURRENCE     = 3'd3,
    REG_MAX_VALUE_LEN  = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_FOUND_FITS = 2'd0,
    ST_TOO_LONG   = 2'd1,
    ST_NOT_FOUND  = 2'd2,
    ST_OVERFLOW   = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] doc_byte;
    logic       region_end;
  } in_word_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [VAL_W-1:0] value_start;
    logic [VAL_W-1:0] value_bytes;
  } out_word_t;

  typedef struct packed {
    logic [4:0]             tag_length;
    logic [8*TAG_BYTES-1:0] tag_chars;
    logic [VAL_W-1:0]       occurrence_index;
    logic [VAL_W-1:0]       max_value_len;
  } cfg_t;

endpackage

### design/xtvl_cfg_regs.sv
// Configuration register file for the XML tag value locator.
`timescale 1ns / 1ps
module xtvl_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [xtvl_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [xtvl_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output xtvl_pkg::cfg_t                     cfg_o
);
  import xtvl_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_TAG_LENGTH:     cfg_d.tag_length = cfg_data_i[4:0];
        REG_TAG_CHARS_LOW:  cfg_d.tag_chars[CFG_DATA_W-1:0] = cfg_data_i;
        REG_TAG_CHARS_HIGH: cfg_d.tag_chars[2*CFG_DATA_W-1:CFG_DATA_W] = cfg_data_i;
        REG_OCCURRENCE:     cfg_d.occurrence_index = cfg_data_i[VAL_W-1:0];
        REG_MAX_VALUE_LEN:  cfg_d.max_value_len = cfg_data_i[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tag_length       <= RST_TAG_LENGTH;
      cfg_q.tag_chars        <= '0;
      cfg_q.occurrence_index <= RST_OCCURRENCE;
      cfg_q.max_value_len    <= RST_MAX_VALUE_LEN;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### design/xtvl_matcher.sv
// Single-counter pattern matcher for the opening and closing tag.
`timescale 1ns / 1ps
module xtvl_matcher #(
  parameter int unsigned MAX_TAG_CHARS = xtvl_pkg::DEF_MAX_TAG_CHARS,
  parameter int unsigned CW            = $clog2(MAX_TAG_CHARS + 4)
) (
  input  logic [CW-1:0]                        cnt_i,
  input  logic [7:0]                           byte_i,
  input  logic [8*xtvl_pkg::TAG_BYTES-1:0]     tag_chars_i,
  input  logic [CW-1:0]                        len_i,
  input  logic                                 closing_i,
  output logic [CW-1:0]                        cnt_o,
  output logic                                 done_o
);
  import xtvl_pkg::*;

  logic [CW-1:0] plen;
  logic [CW-1:0] off;
  logic [CW-1:0] idx;
  logic [CW-1:0] nxt;
  logic [7:0]    tag_b;
  logic [7:0]    want;

  always_comb begin
    plen = closing_i ? len_i + CW'(3) : len_i + CW'(2);
    off  = closing_i ? CW'(2) : CW'(1);
    idx  = cnt_i - off;

    // bytes past the sixteenth tag character read as zero
    tag_b = 8'h00;
    for (int k = 0; k < TAG_BYTES; k++) begin
      if (8'(idx) == 8'(k)) tag_b = tag_chars_i[8*k +: 8];
    end

    if (cnt_i == '0) begin
      want = CHAR_LT;
    end else if (closing_i && cnt_i == CW'(1)) begin
      want = CHAR_SLASH;
    end else if (cnt_i <= len_i + (closing_i ? CW'(1) : CW'(0))) begin
      want = tag_b;
    end else begin
      want = CHAR_GT;
    end

    if (cnt_i < plen && byte_i == want) begin
      nxt = cnt_i + CW'(1);
    end else begin
      // restart, keeping a '<' as the first pattern byte
      nxt = (byte_i == CHAR_LT) ? CW'(1) : CW'(0);
    end

    done_o = (nxt >= plen);
    cnt_o  = done_o ? '0 : nxt;
  end

endmodule

### design/xtvl_search.sv
// Search state, tag tracking and result register of the XML tag value locator.
`timescale 1ns / 1ps
module xtvl_search #(
  parameter int unsigned MAX_TAG_CHARS    = xtvl_pkg::DEF_MAX_TAG_CHARS,
  parameter int unsigned MAX_REGION_BYTES = xtvl_pkg::DEF_MAX_REGION_BYTES
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  xtvl_pkg::cfg_t        cfg_i,
  input  logic                  step_valid_i,
  output logic                  step_ready_o,
  input  xtvl_pkg::in_word_t    step_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output xtvl_pkg::out_word_t   out_data_o
);
  import xtvl_pkg::*;

  localparam int unsigned CW    = $clog2(MAX_TAG_CHARS + 4);
  localparam int unsigned POS_W = $clog2(MAX_REGION_BYTES + 1);
  localparam int unsigned VW    = ((POS_W > VAL_W) ? POS_W : VAL_W) + 1;
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_REGION_BYTES);

  typedef enum logic [1:0] {
    PH_OPEN,
    PH_CLOSE,
    PH_DONE
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [VAL_W-1:0]  occ_q, occ_d;
  logic [POS_W-1:0]  fvs_q, fvs_d;
  logic              out_valid_q, out_valid_d;
  out_word_t         out_q, out_d;

  logic          step_fire;
  logic          emit;
  logic [CW-1:0] len;
  logic [CW-1:0] m_cnt;
  logic          m_done;
  logic [VW-1:0] pos1;
  logic [VW-1:0] vlen;

  assign step_ready_o = !out_valid_q || out_ready_i;
  assign step_fire    = step_valid_i && step_ready_o;
  assign out_valid_o  = out_valid_q;
  assign out_data_o   = out_q;

  // clamp the configured length to one..MAX_TAG_CHARS
  always_comb begin
    if (cfg_i.tag_length == '0) begin
      len = CW'(1);
    end else if (8'(cfg_i.tag_length) > 8'(MAX_TAG_CHARS)) begin
      len = CW'(MAX_TAG_CHARS);
    end else begin
      len = CW'(cfg_i.tag_length);
    end
  end

  xtvl_matcher #(
    .MAX_TAG_CHARS (MAX_TAG_CHARS),
    .CW            (CW)
  ) u_matcher (
    .cnt_i       (cnt_q),
    .byte_i      (step_data_i.doc_byte),
    .tag_chars_i (cfg_i.tag_chars),
    .len_i       (len),
    .closing_i   (phase_q == PH_CLOSE),
    .cnt_o       (m_cnt),
    .done_o      (m_done)
  );

  // value length: closing tag start minus value start
  assign pos1 = VW'(pos_q) + VW'(1);
  assign vlen = pos1 - VW'(len) - VW'(3) - VW'(fvs_q);

  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    cnt_d       = cnt_q;
    occ_d       = occ_q;
    fvs_d       = fvs_q;
    emit        = 1'b0;
    out_d       = '0;
    out_valid_d = out_valid_q && !out_ready_i;

    if (step_fire) begin
      if (pos_q == '0 && phase_q == PH_OPEN) occ_d = cfg_i.occurrence_index;

      if (phase_q != PH_DONE) begin
        if (pos_q == POS_MAX) begin
          emit         = 1'b1;
          out_d.status = ST_OVERFLOW;
          phase_d      = PH_DONE;
        end else if (phase_q == PH_OPEN) begin
          cnt_d = m_cnt;
          if (m_done) begin
            if (occ_d == '0) begin
              fvs_d   = POS_W'(pos1);
              cnt_d   = '0;
              phase_d = PH_CLOSE;
            end else begin
              occ_d = occ_d - VAL_W'(1);
            end
          end
        end else begin
          cnt_d = m_cnt;
          if (m_done) begin
            emit               = 1'b1;
            out_d.status       = (vlen < VW'(cfg_i.max_value_len)) ? ST_FOUND_FITS
                                                                    : ST_TOO_LONG;
            out_d.value_start  = VAL_W'(VW'(fvs_q));
            out_d.value_bytes  = vlen[VAL_W-1:0];
            phase_d            = PH_DONE;
          end
        end
      end

      if (pos_q != POS_MAX) pos_d = pos_q + POS_W'(1);

      if (step_data_i.region_end) begin
        if (!emit && phase_d != PH_DONE) begin
          emit         = 1'b1;
          out_d        = '0;
          out_d.status = ST_NOT_FOUND;
        end
        // start fresh for the next region
        phase_d = PH_OPEN;
        pos_d   = '0;
        cnt_d   = '0;
        occ_d   = cfg_i.occurrence_index;
        fvs_d   = '0;
      end

      if (emit) out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_OPEN;
      pos_q       <= '0;
      cnt_q       <= '0;
      occ_q       <= RST_OCCURRENCE;
      fvs_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      cnt_q       <= cnt_d;
      occ_q       <= occ_d;
      fvs_q       <= fvs_d;
      out_valid_q <= out_valid_d;
      if (emit) out_q <= out_d;
    end
  end

endmodule

### design/xml_tag_value_locator_core.sv
// Path: a word is captured in the input register, matched from there, and its result is held in the result register.
// Throughput: one document byte per cycle while no held result waits on out_ready_i, set by one
// compare of the byte against the tag byte that the match counter selects.
// Results are registered and stall only on out_ready_i.
// Reset: configuration returns to its defaults and the search restarts at region offset 0;
// no clearing pass.
`timescale 1ns / 1ps
module xml_tag_value_locator_core #(
  parameter int unsigned MAX_TAG_CHARS    = xtvl_pkg::DEF_MAX_TAG_CHARS,
  parameter int unsigned MAX_REGION_BYTES = xtvl_pkg::DEF_MAX_REGION_BYTES
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  xtvl_pkg::in_word_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output xtvl_pkg::out_word_t               out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [xtvl_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [xtvl_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import xtvl_pkg::*;

  cfg_t     cfg;
  logic     in_valid_q, in_valid_d;
  in_word_t in_q;
  logic     step_ready;

  xtvl_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // input register: refill in the same cycle the held word moves on
  assign in_ready_o = !in_valid_q || step_ready;

  always_comb begin
    in_valid_d = in_valid_q && !step_ready;
    if (in_valid_i && in_ready_o) in_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_q <= in_data_i;
  end

  xtvl_search #(
    .MAX_TAG_CHARS    (MAX_TAG_CHARS),
    .MAX_REGION_BYTES (MAX_REGION_BYTES)
  ) u_search (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .step_valid_i (in_valid_q),
    .step_ready_o (step_ready),
    .step_data_i  (in_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

  a_empty_takes_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> in_ready_o)
    else $error("input register empty but word refused");

  a_stall_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i && in_valid_q) |-> !in_ready_o)
    else $error("word accepted while result and input register are both held");

  a_miss_fields_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status == ST_NOT_FOUND || out_data_o.status == ST_OVERFLOW))
      |-> (out_data_o.value_start == '0 && out_data_o.value_bytes == '0))
    else $error("miss or overflow result carries nonzero offsets");

  a_result_has_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_q))
    else $error("result appeared without a buffered word");

endmodule
